// ===== src/stic_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, sizes and codes for the sorted table block.
// Used by every module under src; depends on nothing else.
package stic_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int STEP_W  = $clog2(DATA_W);
    localparam int FIELD_W = 7;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_COUNT  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_ZERO_DIV = 2'd2;

    typedef struct packed {
        logic                     command;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] divisor;
    } req_t;

    typedef struct packed {
        logic [FIELD_W-1:0] multiple_count;
        logic [FIELD_W-1:0] fill_level;
        logic [1:0]         status;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic ins_read;
        logic ins_shift;
        logic ins_place;
        logic cnt_read;
        logic div_start;
        logic cnt_next;
        logic result;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_count;
        logic full;
        logic zero_div;
        logic idx_zero;
        logic idx_end;
        logic shift_needed;
        logic div_done;
    } dp_stat_t;

    // Counts wrap to the width of the result fields.
    function automatic logic [FIELD_W-1:0] fit_field(input logic [CNT_W-1:0] c);
        logic [CNT_W+FIELD_W-1:0] w;
        w = {{FIELD_W{1'b0}}, c};
        return w[FIELD_W-1:0];
    endfunction

endpackage

// ===== src/stic_remainder.sv =====
`timescale 1ns / 1ps
// Restoring remainder unit, one quotient bit per cycle.
// Depends on stic_pkg for the data width.
module stic_remainder
    import stic_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              div_done,
    output logic              rem_zero
);

    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] rem_next;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;

    // The partial remainder stays below the divisor, so it fits in DATA_W bits.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DATA_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        rem_next = (trial >= {1'b0, dvs_reg}) ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(DATA_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
        end
    end

    assign div_done = done_reg;
    assign rem_zero = (rem_reg == '0);

endmodule

// ===== src/stic_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: entry memory, index and fill counters, result register.
// Depends on stic_pkg and stic_remainder.
module stic_datapath
    import stic_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  req_t     req,
    input  dp_cmd_t  cmd,
    output dp_stat_t stat,
    output rsp_t     rsp
);

    logic [DATA_W-1:0]        mem [DEPTH];
    logic [DATA_W-1:0]        rdata_reg;
    logic                     command_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0]        dmag_reg;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;
    logic [CNT_W-1:0]         idx_reg;
    logic [CNT_W-1:0]         idx_next;
    logic [CNT_W-1:0]         fill_reg;
    logic [CNT_W-1:0]         fill_next;
    logic [CNT_W-1:0]         mcount_reg;
    logic [CNT_W-1:0]         mcount_next;
    logic [CNT_W-1:0]         idx_m1;
    rsp_t                     rsp_reg;
    logic [DATA_W-1:0]        div_u;
    logic [DATA_W-1:0]        dmag_next;
    logic [DATA_W-1:0]        entry_mag;
    logic [IDX_W-1:0]         raddr;
    logic                     we;
    logic [DATA_W-1:0]        wdata;
    logic                     div_done;
    logic                     rem_zero;

    assign idx_m1 = idx_reg - CNT_W'(1);
    assign div_u  = req.divisor;

    // Divisibility is judged on magnitudes.
    assign dmag_next = div_u[DATA_W-1] ? (DATA_W'(0) - div_u) : div_u;
    assign entry_mag = rdata_reg[DATA_W-1] ? (DATA_W'(0) - rdata_reg) : rdata_reg;

    always_comb
    begin
        status_next = ST_OK;
        if (req.command == CMD_INSERT && fill_reg == CNT_W'(DEPTH))
            status_next = ST_FULL;
        else if (req.command == CMD_COUNT && div_u == '0)
            status_next = ST_ZERO_DIV;
    end

    always_comb
    begin
        idx_next    = idx_reg;
        fill_next   = fill_reg;
        mcount_next = mcount_reg;
        if (cmd.capture)
        begin
            idx_next    = (req.command == CMD_INSERT) ? fill_reg : '0;
            mcount_next = '0;
        end
        if (cmd.ins_shift)
            idx_next = idx_m1;
        if (cmd.ins_place)
            fill_next = fill_reg + CNT_W'(1);
        if (cmd.cnt_next)
        begin
            idx_next = idx_reg + CNT_W'(1);
            if (rem_zero)
                mcount_next = mcount_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            fill_reg   <= '0;
            mcount_reg <= '0;
        end
        else
        begin
            idx_reg    <= idx_next;
            fill_reg   <= fill_next;
            mcount_reg <= mcount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            command_reg <= req.command;
            value_reg   <= req.value;
            dmag_reg    <= dmag_next;
            status_reg  <= status_next;
        end
        if (cmd.result)
        begin
            rsp_reg.multiple_count <= fit_field(mcount_reg);
            rsp_reg.fill_level     <= fit_field(fill_reg);
            rsp_reg.status         <= status_reg;
        end
    end

    // Insert walks down from the end, moving each entry not below the new value up one slot.
    assign raddr = cmd.ins_read ? idx_m1[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign we    = cmd.ins_shift | cmd.ins_place;
    assign wdata = cmd.ins_shift ? rdata_reg : value_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[idx_reg[IDX_W-1:0]] <= wdata;
        if (cmd.ins_read || cmd.cnt_read)
            rdata_reg <= mem[raddr];
    end

    stic_remainder u_remainder (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (entry_mag),
        .divisor  (dmag_reg),
        .div_done (div_done),
        .rem_zero (rem_zero)
    );

    always_comb
    begin
        stat.is_count     = (command_reg == CMD_COUNT);
        stat.full         = (status_reg == ST_FULL);
        stat.zero_div     = (status_reg == ST_ZERO_DIV);
        stat.idx_zero     = (idx_reg == '0);
        stat.idx_end      = (idx_reg == fill_reg);
        stat.shift_needed = ($signed(rdata_reg) >= value_reg);
        stat.div_done     = div_done;
    end

    assign rsp = rsp_reg;

endmodule

// ===== src/stic_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences insert and count walks, owns both handshakes.
// Depends on stic_pkg for the command and status structs.
module stic_ctrl
    import stic_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECIDE  = 4'd1;
    localparam logic [3:0] S_INS_CHK = 4'd2;
    localparam logic [3:0] S_INS_CMP = 4'd3;
    localparam logic [3:0] S_CNT_CHK = 4'd4;
    localparam logic [3:0] S_CNT_DAT = 4'd5;
    localparam logic [3:0] S_DIV     = 4'd6;
    localparam logic [3:0] S_DONE    = 4'd7;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.full || stat.zero_div)
                    state_next = S_DONE;
                else if (stat.is_count)
                    state_next = S_CNT_CHK;
                else
                    state_next = S_INS_CHK;
            end
            S_INS_CHK:
            begin
                if (stat.idx_zero)
                begin
                    cmd.ins_place = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.ins_read = 1'b1;
                    state_next   = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (stat.shift_needed)
                begin
                    cmd.ins_shift = 1'b1;
                    state_next    = S_INS_CHK;
                end
                else
                begin
                    cmd.ins_place = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_CNT_CHK:
            begin
                if (stat.idx_end)
                    state_next = S_DONE;
                else
                begin
                    cmd.cnt_read = 1'b1;
                    state_next   = S_CNT_DAT;
                end
            end
            S_CNT_DAT:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.cnt_next = 1'b1;
                    state_next   = S_CNT_CHK;
                end
            end
            S_DONE:
            begin
                // The result register is loaded only once the previous beat has left.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.result = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.result)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ===== src/sorted_table_insert_count_multiples_core.sv =====
`timescale 1ns / 1ps
// Top level of the sorted table: ordered insert and count of multiples.
// Depends on stic_pkg, stic_ctrl, stic_datapath (and stic_remainder below it).
//
//   Channel  Handshake              Beat type  Carries
//   req      req_valid / req_ready  req_t      command, value, divisor
//   rsp      rsp_valid / rsp_ready  rsp_t      multiple_count, fill_level, status
//
// One command is worked at a time. An insert needs a memory read and a write for each
// entry that it moves up. A count takes per entry one read, one start and a run of the
// bit-serial remainder unit. Rejected inserts and zero divisors skip the table walk.
// Reset empties the table at once. A waiting result does not block the next request;
// only the final result load waits for rsp_ready.
module sorted_table_insert_count_multiples_core
    import stic_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    stic_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    stic_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule
